/* rtl/softened_pairwise_gravity_accel_top_macros.svh */
// Assertion macros shared by the gravity block.
`ifndef SOFTENED_PAIRWISE_GRAVITY_ACCEL_TOP_MACROS_SVH
`define SOFTENED_PAIRWISE_GRAVITY_ACCEL_TOP_MACROS_SVH

// Implication checked every cycle outside reset.
`define SPGA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle consequence, checked during reset as well.
`define SPGA_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/spga_pkg.sv */
// Package: types and constants of the softened pairwise gravity block.
`timescale 1ns / 1ps

package spga_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_W         = 32;
    localparam int ADDR_W        = 3;

    localparam logic [REG_W-1:0] GRAV_RESET = 32'h0001_0000;
    localparam logic [REG_W-1:0] SOFT_RESET = 32'h0001_0000;

    typedef enum logic [0:0] {
        REG_GRAV = 1'b0,
        REG_SOFT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] source_x;
        logic signed [COORD_W-1:0] source_y;
        logic        [REG_W-1:0]   source_mass;
        logic                      is_self;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] accel_x;
        logic signed [COORD_W-1:0] accel_y;
        logic                      saturated;
    } out_word_t;

endpackage

/* rtl/softened_pairwise_gravity_accel_top.sv */
// Top level: softened pairwise gravitational acceleration pipeline.
`timescale 1ns / 1ps

// Streams one body pair per clock unless a held result stalls the pipe: a new
// word can enter every cycle and a result word leaves every cycle once the pipe
// is full. The pipe runs through the digit-serial square root (one root bit per
// stage) and then the two restoring dividers (one quotient bit per stage), which
// work side by side on x and y. A held result only stalls the pipe when the last
// stage also holds a word; bubbles still drain behind it.
// Write G and the softening term only while no word is in flight.

`include "softened_pairwise_gravity_accel_top_macros.svh"

module softened_pairwise_gravity_accel_top #(
    parameter int FRAC_BITS = spga_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  spga_pkg::in_word_t             s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output spga_pkg::out_word_t            m_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spga_pkg::ADDR_W-1:0]    paddr,
    input  logic [spga_pkg::REG_W-1:0]     pwdata,
    output logic [spga_pkg::REG_W-1:0]     prdata,
    output logic                           pready
);

    localparam int CW     = spga_pkg::COORD_W;
    localparam int RW     = spga_pkg::REG_W;
    localparam int R2_W   = 2 * CW + 1;
    localparam int RT_W   = CW + 1;
    localparam int RR_W   = 2 * RT_W;
    localparam int R3_W   = RR_W + RT_W;
    localparam int SOFT_W = RW + 2 * FRAC_BITS;
    localparam int DEN_W  = ((R3_W > SOFT_W) ? R3_W : SOFT_W) + 1;
    localparam int GM_W   = 2 * RW;
    localparam int GX_W   = GM_W + CW;
    localparam int NUM_W  = GX_W + FRAC_BITS;
    localparam int SIDE_W = 2 * CW + 2 + RW + 1;

    localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] NEG_MAX = {1'b1, {(CW-1){1'b0}}};

    // configuration
    logic [RW-1:0] grav_reg;
    logic [RW-1:0] soft_reg;
    spga_pkg::reg_idx_t cfg_idx;

    assign cfg_idx = spga_pkg::reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= spga_pkg::GRAV_RESET;
            soft_reg <= spga_pkg::SOFT_RESET;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                spga_pkg::REG_GRAV: grav_reg <= pwdata;
                spga_pkg::REG_SOFT: soft_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            spga_pkg::REG_GRAV: prdata = grav_reg;
            spga_pkg::REG_SOFT: prdata = soft_reg;
            default:            prdata = '0;
        endcase
    end

    // flow control
    logic m_valid_reg;
    spga_pkg::out_word_t m_word_reg;
    logic out_free;
    logic en;
    logic vdx;
    logic vdy;

    assign out_free = !m_valid_reg || m_ready;
    assign en       = out_free || !vdx;
    assign s_ready  = en;

    // stage 1: differences in sign-magnitude form
    logic [CW-1:0] tx_off, ty_off, sx_off, sy_off;
    logic          gex, gey;
    logic [CW-1:0] mx_next, my_next;
    logic          zero_next;

    always_comb begin
        tx_off    = {~s_word.target_x[CW-1], s_word.target_x[CW-2:0]};
        ty_off    = {~s_word.target_y[CW-1], s_word.target_y[CW-2:0]};
        sx_off    = {~s_word.source_x[CW-1], s_word.source_x[CW-2:0]};
        sy_off    = {~s_word.source_y[CW-1], s_word.source_y[CW-2:0]};
        gex       = sx_off >= tx_off;
        gey       = sy_off >= ty_off;
        mx_next   = gex ? (sx_off - tx_off) : (tx_off - sx_off);
        my_next   = gey ? (sy_off - ty_off) : (ty_off - sy_off);
        zero_next = s_word.is_self || ((sx_off == tx_off) && (sy_off == ty_off));
    end

    logic          v1_reg, v2_reg, v3_reg;
    logic [CW-1:0] mx1_reg, my1_reg, mx2_reg, my2_reg, mx3_reg, my3_reg;
    logic          nx1_reg, ny1_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg;
    logic          z1_reg, z2_reg, z3_reg;
    logic [RW-1:0] mass1_reg, mass2_reg, mass3_reg;
    logic [2*CW-1:0] sqx2_reg, sqy2_reg;
    logic [R2_W-1:0] r2_3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx1_reg   <= mx_next;
            my1_reg   <= my_next;
            nx1_reg   <= !gex;
            ny1_reg   <= !gey;
            z1_reg    <= zero_next;
            mass1_reg <= s_word.source_mass;

            sqx2_reg  <= (2*CW)'(mx1_reg) * (2*CW)'(mx1_reg);
            sqy2_reg  <= (2*CW)'(my1_reg) * (2*CW)'(my1_reg);
            mx2_reg   <= mx1_reg;
            my2_reg   <= my1_reg;
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
            z2_reg    <= z1_reg;
            mass2_reg <= mass1_reg;

            r2_3_reg  <= R2_W'(sqx2_reg) + R2_W'(sqy2_reg);
            mx3_reg   <= mx2_reg;
            my3_reg   <= my2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;
            z3_reg    <= z2_reg;
            mass3_reg <= mass2_reg;
        end
    end

    // square root
    logic              vq;
    logic [RT_W-1:0]   root_q;
    logic [SIDE_W-1:0] side_q;
    logic [CW-1:0]     mx_q, my_q;
    logic              nx_q, ny_q, z_q;
    logic [RW-1:0]     mass_q;

    spga_isqrt #(
        .ROOT_W (RT_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    ((2*RT_W)'(r2_3_reg)),
        .in_side   ({mx3_reg, nx3_reg, my3_reg, ny3_reg, mass3_reg, z3_reg}),
        .out_valid (vq),
        .out_root  (root_q),
        .out_side  (side_q)
    );

    assign {mx_q, nx_q, my_q, ny_q, mass_q, z_q} = side_q;

    // stages 4 to 7: cube, G*mass, numerators, denominator
    logic              v4_reg, v5_reg, v6_reg, v7_reg;
    logic [RR_W-1:0]   rr4_reg;
    logic [GM_W-1:0]   gm4_reg;
    logic [RT_W-1:0]   root4_reg;
    logic [CW-1:0]     mx4_reg, my4_reg;
    logic              nx4_reg, ny4_reg, nx5_reg, ny5_reg, nx6_reg, ny6_reg;
    logic              nx7_reg, ny7_reg;
    logic              z4_reg, z5_reg, z6_reg, z7_reg;
    logic [CW+RT_W-1:0]        r3a5_reg;
    logic [RR_W-CW+RT_W-1:0]   r3b5_reg;
    logic [RW+CW-1:0]  gxa5_reg, gxb5_reg, gya5_reg, gyb5_reg;
    logic [R3_W-1:0]   r3_6_reg;
    logic [NUM_W-1:0]  numx6_reg, numy6_reg, numx7_reg, numy7_reg;
    logic [DEN_W-1:0]  den7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= vq;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rr4_reg   <= RR_W'(root_q) * RR_W'(root_q);
            gm4_reg   <= GM_W'(grav_reg) * GM_W'(mass_q);
            root4_reg <= root_q;
            mx4_reg   <= mx_q;
            my4_reg   <= my_q;
            nx4_reg   <= nx_q;
            ny4_reg   <= ny_q;
            z4_reg    <= z_q;

            r3a5_reg  <= (CW+RT_W)'(rr4_reg[CW-1:0]) * (CW+RT_W)'(root4_reg);
            r3b5_reg  <= (RR_W-CW+RT_W)'(rr4_reg[RR_W-1:CW])
                         * (RR_W-CW+RT_W)'(root4_reg);
            gxa5_reg  <= (RW+CW)'(gm4_reg[RW-1:0]) * (RW+CW)'(mx4_reg);
            gxb5_reg  <= (RW+CW)'(gm4_reg[GM_W-1:RW]) * (RW+CW)'(mx4_reg);
            gya5_reg  <= (RW+CW)'(gm4_reg[RW-1:0]) * (RW+CW)'(my4_reg);
            gyb5_reg  <= (RW+CW)'(gm4_reg[GM_W-1:RW]) * (RW+CW)'(my4_reg);
            nx5_reg   <= nx4_reg;
            ny5_reg   <= ny4_reg;
            z5_reg    <= z4_reg;

            r3_6_reg  <= R3_W'(r3a5_reg) + (R3_W'(r3b5_reg) << CW);
            numx6_reg <= NUM_W'(GX_W'(gxa5_reg) + (GX_W'(gxb5_reg) << RW)) << FRAC_BITS;
            numy6_reg <= NUM_W'(GX_W'(gya5_reg) + (GX_W'(gyb5_reg) << RW)) << FRAC_BITS;
            nx6_reg   <= nx5_reg;
            ny6_reg   <= ny5_reg;
            z6_reg    <= z5_reg;

            den7_reg  <= DEN_W'(r3_6_reg) + (DEN_W'(soft_reg) << (2 * FRAC_BITS));
            numx7_reg <= numx6_reg;
            numy7_reg <= numy6_reg;
            nx7_reg   <= nx6_reg;
            ny7_reg   <= ny6_reg;
            z7_reg    <= z6_reg;
        end
    end

    // dividers
    logic [CW-1:0] qx, qy;
    logic          ovfx, ovfy;
    logic          z_d, nx_d, ny_d;

    spga_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .Q_W    (CW),
        .SIDE_W (2)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_num    (numx7_reg),
        .in_den    (den7_reg),
        .in_side   ({z7_reg, nx7_reg}),
        .out_valid (vdx),
        .out_quot  (qx),
        .out_ovf   (ovfx),
        .out_side  ({z_d, nx_d})
    );

    spga_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .Q_W    (CW),
        .SIDE_W (1)
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_num    (numy7_reg),
        .in_den    (den7_reg),
        .in_side   (ny7_reg),
        .out_valid (vdy),
        .out_quot  (qy),
        .out_ovf   (ovfy),
        .out_side  (ny_d)
    );

    // clip and apply sign; returns {clipped, value}
    function automatic logic [CW:0] clip(logic [CW-1:0] q, logic ovf, logic neg);
        logic [CW-1:0] lim;
        logic [CW-1:0] m;
        logic          sat;
        lim = neg ? NEG_MAX : POS_MAX;
        sat = ovf || (q > lim);
        m   = sat ? lim : q;
        return {sat, neg ? CW'(~m + 1'b1) : m};
    endfunction

    logic [CW:0]         cx, cy;
    spga_pkg::out_word_t m_word_next;

    always_comb begin
        cx = clip(qx, ovfx, nx_d);
        cy = clip(qy, ovfy, ny_d);
        if (z_d) begin
            m_word_next = '0;
        end else begin
            m_word_next.accel_x   = cx[CW-1:0];
            m_word_next.accel_y   = cy[CW-1:0];
            m_word_next.saturated = cx[CW] || cy[CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= vdx;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && vdx) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    logic sat_hold;
    logic at_lim;

    assign sat_hold = m_valid_reg && m_word_reg.saturated;
    assign at_lim   = m_word_reg.accel_x == POS_MAX || m_word_reg.accel_x == NEG_MAX
                      || m_word_reg.accel_y == POS_MAX || m_word_reg.accel_y == NEG_MAX;

    `SPGA_ASSERT_IMPL(a_lanes_aligned, aclk, aresetn, 1'b1, vdx == vdy, "divider lanes out of step")
    `SPGA_ASSERT_IMPL(a_sat_at_limit, aclk, aresetn, sat_hold, at_lim, "clipped word not at a limit")
    `SPGA_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid_reg, "result valid right after reset")

endmodule

/* rtl/spga_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps

module spga_isqrt #(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int REM_W = ROOT_W + 3;

    logic                v_reg    [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W];
    logic [REM_W-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [SIDE_W-1:0]   side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int I = ROOT_W - 1 - k;
        logic                v_in;
        logic [2*ROOT_W-1:0] rad_in;
        logic [REM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [SIDE_W-1:0]   side_in;
        logic [REM_W-1:0]    rem_sh;
        logic [REM_W-1:0]    trial;
        logic                fit;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[2*I+1 -: 2]};
            trial  = {REM_W'(root_in) << 2} | REM_W'(1);
            fit    = rem_sh >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= fit ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[ROOT_W-2:0], fit};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

/* rtl/spga_div.sv */
// Pipelined restoring divider lane with quotient overflow detect.
`timescale 1ns / 1ps

module spga_div #(
    parameter int NUM_W  = 112,
    parameter int DEN_W  = 100,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic              out_ovf,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CMP_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

    logic              v0_reg;
    logic [NUM_W-1:0]  rem0_reg;
    logic [DEN_W-1:0]  den0_reg;
    logic              ovf0_reg;
    logic [SIDE_W-1:0] side0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg  <= in_num;
            den0_reg  <= in_den;
            ovf0_reg  <= CMP_W'(in_num) >= (CMP_W'(in_den) << Q_W);
            side0_reg <= in_side;
        end
    end

    logic              v_reg    [Q_W];
    logic [NUM_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic              ovf_reg  [Q_W];
    logic [Q_W-1:0]    quot_reg [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int I = Q_W - 1 - k;
        logic              v_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic              ovf_in;
        logic [Q_W-1:0]    quot_in;
        logic [SIDE_W-1:0] side_in;
        logic [CMP_W-1:0]  dsh;
        logic [CMP_W-1:0]  diff;
        logic              fit;

        if (k == 0) begin : g_first
            assign v_in    = v0_reg;
            assign rem_in  = rem0_reg;
            assign den_in  = den0_reg;
            assign ovf_in  = ovf0_reg;
            assign quot_in = '0;
            assign side_in = side0_reg;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign ovf_in  = ovf_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            dsh  = CMP_W'(den_in) << I;
            fit  = CMP_W'(rem_in) >= dsh;
            diff = CMP_W'(rem_in) - dsh;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fit ? diff[NUM_W-1:0] : rem_in;
                den_reg[k]  <= den_in;
                ovf_reg[k]  <= ovf_in;
                quot_reg[k] <= (quot_in << 1) | Q_W'(fit);
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_ovf   = ovf_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

/* sim/tb_top.sv */
// Testbench for the softened pairwise gravity block: predicts and checks each result word.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 2 * spga_pkg::COORD_W + 10;
    localparam int LIMIT   = 600000;
    localparam int AW      = spga_pkg::ADDR_W;
    localparam int RW      = spga_pkg::REG_W;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    spga_pkg::in_word_t  s_word = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    spga_pkg::out_word_t m_word;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AW-1:0]       paddr = '0;
    logic [RW-1:0]       pwdata = '0;
    logic [RW-1:0]       prdata;
    logic                pready;

    softened_pairwise_gravity_accel_top dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    logic [31:0] g_reg, soft_reg;
    spga_pkg::out_word_t accel_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          hold_off = 0;
    int          stall_pct = 30;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [127:0] isqrt(input logic [127:0] n);
        logic [63:0]  res;
        logic [63:0]  cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
        end
        return {64'd0, res};
    endfunction

    function automatic logic [31:0] accel_part(input logic [127:0] gm, input logic [63:0] mag,
                                               input logic neg, input logic [127:0] den,
                                               inout logic sat);
        logic [127:0] num, q, lim;
        logic [31:0]  m;
        num = (gm * {64'd0, mag}) << 16;
        q = num / den;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        m = q[31:0];
        if (q > lim) begin
            m = lim[31:0];
            sat = 1'b1;
        end
        return neg ? -m : m;
    endfunction

    function automatic spga_pkg::out_word_t predict_accel(input spga_pkg::in_word_t w);
        spga_pkg::out_word_t r;
        logic [63:0]  dx, dy, mx, my;
        logic         nx, ny, sat;
        logic [127:0] rr, den, gm;
        r = '0;
        sat = 1'b0;
        dx = 64'(signed'(w.source_x)) - 64'(signed'(w.target_x));
        dy = 64'(signed'(w.source_y)) - 64'(signed'(w.target_y));
        nx = dx[63];
        ny = dy[63];
        mx = nx ? -dx : dx;
        my = ny ? -dy : dy;
        if (w.is_self || (mx == 0 && my == 0)) return r;
        rr = isqrt({64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my});
        den = rr * rr * rr + ({96'd0, soft_reg} << 32);
        gm = {96'd0, g_reg} * {96'd0, w.source_mass};
        r.accel_x = accel_part(gm, mx, nx, den, sat);
        r.accel_y = accel_part(gm, my, ny, den, sat);
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (accel_q.size() == 0) begin
                report("unexpected word", m_word.accel_x, 32'd0);
            end else begin
                spga_pkg::out_word_t e;
                e = accel_q.pop_front();
                if (m_word.accel_x !== e.accel_x) report("accel_x", m_word.accel_x, e.accel_x);
                if (m_word.accel_y !== e.accel_y) report("accel_y", m_word.accel_y, e.accel_y);
                if (m_word.saturated !== e.saturated)
                    report("saturated", 32'(m_word.saturated), 32'(e.saturated));
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_off <= 400;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic reg_write(input spga_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AW'(4 * int'(idx));
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == spga_pkg::REG_GRAV) g_reg = val;
        else soft_reg = val;
        @(posedge aclk);
        if (prdata !== val) report("readback", prdata, val);
        if (pready !== 1'b1) report("pready", 32'(pready), 32'd1);
    endtask

    int burst_left = 0;

    task automatic send_pair(input spga_pkg::in_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_word <= w;
        accel_q.push_back(predict_accel(w));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        int n;
        n = 0;
        s_valid <= 1'b0;
        while (accel_q.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (accel_q.size() != 0) report("words missing", 32'(accel_q.size()), 32'd0);
    endtask

    function automatic logic [31:0] rand_coord(input int span);
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(0, span)) - 32'(span / 2);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic spga_pkg::in_word_t rand_pair;
        spga_pkg::in_word_t w;
        w.target_x = rand_coord(1 << 22);
        w.target_y = rand_coord(1 << 22);
        w.source_x = $urandom_range(0, 7) == 0 ? w.target_x : rand_coord(1 << 22);
        w.source_y = $urandom_range(0, 7) == 0 ? w.target_y : rand_coord(1 << 22);
        w.source_mass = $urandom_range(0, 5) == 0 ? 32'hffff_ffff : $urandom;
        w.is_self = ($urandom_range(0, 15) == 0);
        return w;
    endfunction

    task automatic test_directed;
        spga_pkg::in_word_t w;
        logic [31:0] ext[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w = '0;
                w.target_x = ext[i];
                w.target_y = ext[j];
                w.source_x = ext[3 - i];
                w.source_y = ext[j ^ 1];
                w.source_mass = (i + j) % 2 ? 32'hffff_ffff : 32'h0001_0000;
                send_pair(w);
            end
        end
        w = '0;
        w.source_x = 32'h0001_0000;
        w.source_mass = 32'h0001_0000;
        w.is_self = 1'b1;
        send_pair(w);
        w.is_self = 1'b0;
        send_pair(w);
        w.source_x = '0;
        send_pair(w);
        w.source_x = 32'h0000_0001;
        w.source_mass = 32'hffff_ffff;
        send_pair(w);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_pair(rand_pair());
    endtask

    task automatic test_backpressure;
        hold_req = 1'b1;
        stall_pct = 0;
        test_random(150);
        stall_pct = 30;
    endtask

    initial begin
        g_reg = spga_pkg::GRAV_RESET;
        soft_reg = spga_pkg::SOFT_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(200);
        drain();
        reg_write(spga_pkg::REG_GRAV, 32'hffff_ffff);
        reg_write(spga_pkg::REG_SOFT, 32'h0);
        test_directed();
        test_random(150);
        drain();
        reg_write(spga_pkg::REG_GRAV, 32'h0);
        reg_write(spga_pkg::REG_SOFT, 32'hffff_ffff);
        test_random(60);
        drain();
        reg_write(spga_pkg::REG_GRAV, $urandom);
        reg_write(spga_pkg::REG_SOFT, $urandom_range(0, 1 << 20));
        test_backpressure();
        test_random(250);
        drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
